// ----- hw/rtl/tcw_pkg.sv -----
package tcw_pkg;

  localparam logic [1:0] KIND_PUT   = 2'd0;
  localparam logic [1:0] KIND_CLEAR = 2'd1;
  localparam logic [1:0] KIND_READ  = 2'd2;

  localparam logic [7:0] NEWLINE_CODE = 8'h0A;
  localparam logic [7:0] SPACE_CODE   = 8'h20;
  localparam logic [7:0] ATTR_RESET   = 8'h0F;

  typedef enum logic [2:0] {
    OP_GLYPH,
    OP_NEWLINE,
    OP_CLEAR,
    OP_READ,
    OP_NOP
  } op_e;

  typedef enum logic [1:0] {
    ST_SWEEP,
    ST_IDLE,
    ST_READ
  } state_e;

  typedef struct packed {
    op_e         op;
    logic [7:0]  char_code;
    logic [10:0] cell_address;
    logic        in_range;
  } cmd_t;

  typedef struct packed {
    logic pop;
    logic init_done;
  } bk_status_t;

endpackage

// ----- hw/rtl/tcw_if.sv -----
interface tcw_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [7:0]  char_code;
  logic [10:0] cell_address;

  modport source (output valid, kind, char_code, cell_address, input ready);
  modport sink (input valid, kind, char_code, cell_address, output ready);
endinterface

interface tcw_out_if;
  logic        valid;
  logic        ready;
  logic [10:0] cursor_position;
  logic [15:0] cell_data;
  logic        scrolled;

  modport source (output valid, cursor_position, cell_data, scrolled, input ready);
  modport sink (input valid, cursor_position, cell_data, scrolled, output ready);
endinterface

interface tcw_cfg_if;
  logic       valid;
  logic       ready;
  logic [7:0] text_attribute;

  modport source (output valid, text_attribute, input ready);
  modport sink (input valid, text_attribute, output ready);
endinterface

// ----- hw/rtl/tcw_ram.sv -----
module tcw_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2000
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[addr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- hw/rtl/tcw_front.sv -----
module tcw_front import tcw_pkg::*; #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  tcw_in_if.sink     in_i,
  input  bk_status_t status_i,
  output logic       cmd_valid_o,
  output cmd_t       cmd_o
);

  localparam int CELL_COUNT = COLUMNS * ROWS;

  cmd_t       queue_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] cnt_q, cnt_d;
  cmd_t       dec;
  logic       push;

  // Classify the incoming transaction
  always_comb begin
    dec.char_code    = in_i.char_code;
    dec.cell_address = in_i.cell_address;
    dec.in_range     = 32'(in_i.cell_address) < CELL_COUNT;
    unique case (in_i.kind)
      KIND_PUT:   dec.op = (in_i.char_code == NEWLINE_CODE) ? OP_NEWLINE : OP_GLYPH;
      KIND_CLEAR: dec.op = OP_CLEAR;
      KIND_READ:  dec.op = OP_READ;
      default:    dec.op = OP_NOP;
    endcase
  end

  assign in_i.ready  = status_i.init_done && (cnt_q != 2'd2);
  assign push        = in_i.valid && in_i.ready;
  assign cmd_valid_o = cnt_q != 2'd0;
  assign cmd_o       = queue_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = status_i.pop ? ~rd_ptr_q : rd_ptr_q;
    cnt_d    = cnt_q + 2'(push) - 2'(status_i.pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      queue_q[wr_ptr_q] <= dec;
    end
  end

endmodule

// ----- hw/rtl/tcw_back.sv -----
module tcw_back import tcw_pkg::*; #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cmd_valid_i,
  input  cmd_t       cmd_i,
  input  logic [7:0] attr_i,
  output bk_status_t status_o,
  tcw_out_if.source  out_o
);

  localparam int CELL_COUNT    = COLUMNS * ROWS;
  localparam int AW            = $clog2(CELL_COUNT);
  localparam int CW            = $clog2(COLUMNS);
  localparam int LAST_ROW_BASE = (ROWS - 1) * COLUMNS;

  state_e        state_q, state_d;
  logic [AW-1:0] pos_q, pos_d;
  logic [CW-1:0] col_q, col_d;
  logic [AW-1:0] base_q, base_d;
  logic [AW-1:0] sweep_addr_q, sweep_addr_d;
  logic [AW-1:0] sweep_last_q, sweep_last_d;
  logic [15:0]   blank_q, blank_d;
  logic          emit_q, emit_d;
  logic          init_done_q, init_done_d;
  logic          scr_q, scr_d;
  logic          rd_hit_q, rd_hit_d;
  logic          out_valid_q, out_valid_d;
  logic [10:0]   out_pos_q, out_pos_d;
  logic [15:0]   out_data_q, out_data_d;
  logic          out_scr_q, out_scr_d;

  logic          out_free, pop, last_row, last_col, sweep_end;
  logic [AW:0]   cur_sum, rd_sum;
  logic [AW-1:0] cur_phys, rd_phys, base_next;
  logic          ram_we, ram_re;
  logic [AW-1:0] ram_addr;
  logic [15:0]   ram_wdata, ram_rdata;
  logic          ld, ld_scr;
  logic [15:0]   ld_data;

  // Rows live in a ring: base_q is the physical start of the top row
  assign cur_sum  = {1'b0, pos_q} + {1'b0, base_q};
  assign cur_phys = (cur_sum >= (AW+1)'(CELL_COUNT)) ?
                    AW'(cur_sum - (AW+1)'(CELL_COUNT)) : AW'(cur_sum);
  assign rd_sum   = {1'b0, AW'(cmd_i.cell_address)} + {1'b0, base_q};
  assign rd_phys  = (rd_sum >= (AW+1)'(CELL_COUNT)) ?
                    AW'(rd_sum - (AW+1)'(CELL_COUNT)) : AW'(rd_sum);
  assign base_next = (base_q == AW'(CELL_COUNT - COLUMNS)) ? '0 : base_q + AW'(COLUMNS);

  assign out_free  = !out_valid_q || out_o.ready;
  assign pop       = (state_q == ST_IDLE) && cmd_valid_i && out_free;
  assign last_row  = pos_q >= AW'(LAST_ROW_BASE);
  assign last_col  = col_q == CW'(COLUMNS - 1);
  assign sweep_end = sweep_addr_q == sweep_last_q;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_SWEEP: begin
        if (sweep_end) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (pop) begin
          unique case (cmd_i.op)
            OP_GLYPH:   if (last_col && last_row) state_d = ST_SWEEP;
            OP_NEWLINE: if (last_row) state_d = ST_SWEEP;
            OP_CLEAR:   state_d = ST_SWEEP;
            OP_READ:    state_d = ST_READ;
            default:    state_d = ST_IDLE;
          endcase
        end
      end
      ST_READ:  state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    pos_d        = pos_q;
    col_d        = col_q;
    base_d       = base_q;
    sweep_addr_d = sweep_addr_q;
    sweep_last_d = sweep_last_q;
    blank_d      = blank_q;
    emit_d       = emit_q;
    init_done_d  = init_done_q;
    scr_d        = scr_q;
    rd_hit_d     = rd_hit_q;
    ram_we       = 1'b0;
    ram_re       = 1'b0;
    ram_addr     = cur_phys;
    ram_wdata    = {attr_i, cmd_i.char_code};
    ld           = 1'b0;
    ld_data      = 16'h0000;
    ld_scr       = 1'b0;

    unique case (state_q)
      ST_SWEEP: begin
        ram_we       = 1'b1;
        ram_addr     = sweep_addr_q;
        ram_wdata    = blank_q;
        sweep_addr_d = sweep_addr_q + 1'b1;
        if (sweep_end) begin
          init_done_d = 1'b1;
          emit_d      = 1'b0;
          ld          = emit_q;
          ld_scr      = scr_q;
        end
      end
      ST_IDLE: begin
        if (pop) begin
          unique case (cmd_i.op)
            OP_GLYPH: begin
              ram_we = 1'b1;
              if (last_col) begin
                col_d = '0;
                if (last_row) begin
                  pos_d        = AW'(LAST_ROW_BASE);
                  sweep_addr_d = base_q;
                  sweep_last_d = base_q + AW'(COLUMNS - 1);
                  base_d       = base_next;
                  blank_d      = {attr_i, SPACE_CODE};
                  emit_d       = 1'b1;
                  scr_d        = 1'b1;
                end else begin
                  pos_d = pos_q + 1'b1;
                  ld    = 1'b1;
                end
              end else begin
                col_d = col_q + 1'b1;
                pos_d = pos_q + 1'b1;
                ld    = 1'b1;
              end
            end
            OP_NEWLINE: begin
              col_d = '0;
              if (last_row) begin
                pos_d        = AW'(LAST_ROW_BASE);
                sweep_addr_d = base_q;
                sweep_last_d = base_q + AW'(COLUMNS - 1);
                base_d       = base_next;
                blank_d      = {attr_i, SPACE_CODE};
                emit_d       = 1'b1;
                scr_d        = 1'b1;
              end else begin
                pos_d = pos_q - AW'(col_q) + AW'(COLUMNS);
                ld    = 1'b1;
              end
            end
            OP_CLEAR: begin
              pos_d        = '0;
              col_d        = '0;
              base_d       = '0;
              sweep_addr_d = '0;
              sweep_last_d = AW'(CELL_COUNT - 1);
              blank_d      = {attr_i, SPACE_CODE};
              emit_d       = 1'b1;
              scr_d        = 1'b0;
            end
            OP_READ: begin
              ram_re   = cmd_i.in_range;
              ram_addr = rd_phys;
              rd_hit_d = cmd_i.in_range;
            end
            default: ld = 1'b1;
          endcase
        end
      end
      ST_READ: begin
        // Output slot is empty here: nothing was loaded when the read was issued
        ld      = 1'b1;
        ld_data = rd_hit_q ? ram_rdata : 16'h0000;
      end
      default: ;
    endcase

    out_valid_d = out_valid_q && !out_o.ready;
    out_pos_d   = out_pos_q;
    out_data_d  = out_data_q;
    out_scr_d   = out_scr_q;
    if (ld) begin
      out_valid_d = 1'b1;
      out_pos_d   = 11'(pos_d);
      out_data_d  = ld_data;
      out_scr_d   = ld_scr;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_SWEEP;
      pos_q        <= '0;
      col_q        <= '0;
      base_q       <= '0;
      sweep_addr_q <= '0;
      sweep_last_q <= AW'(CELL_COUNT - 1);
      blank_q      <= {ATTR_RESET, SPACE_CODE};
      emit_q       <= 1'b0;
      init_done_q  <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      pos_q        <= pos_d;
      col_q        <= col_d;
      base_q       <= base_d;
      sweep_addr_q <= sweep_addr_d;
      sweep_last_q <= sweep_last_d;
      blank_q      <= blank_d;
      emit_q       <= emit_d;
      init_done_q  <= init_done_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    scr_q      <= scr_d;
    rd_hit_q   <= rd_hit_d;
    out_pos_q  <= out_pos_d;
    out_data_q <= out_data_d;
    out_scr_q  <= out_scr_d;
  end

  tcw_ram #(
    .WIDTH (16),
    .DEPTH (CELL_COUNT)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .re_i    (ram_re),
    .addr_i  (ram_addr),
    .wdata_i (ram_wdata),
    .rdata_o (ram_rdata)
  );

  assign status_o.pop       = pop;
  assign status_o.init_done = init_done_q;

  assign out_o.valid           = out_valid_q;
  assign out_o.cursor_position = out_pos_q;
  assign out_o.cell_data       = out_data_q;
  assign out_o.scrolled        = out_scr_q;

endmodule

// ----- hw/rtl/text_console_writer.sv -----
// A transaction waits in the front end's two-entry command queue; the back end takes
// it once the result register is free and loads its result there (a read after the
// single-port cell RAM is read, a scroll or clear after its blanking sweep ends).
// Scrolling rotates a row base pointer, so only the new bottom row is rewritten.
// Reset: cursor homed, attribute 0x0F; a clearing pass then blanks the RAM, and no input
// transaction is taken until it ends.
module text_console_writer import tcw_pkg::*; #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  tcw_in_if.sink     in_i,
  tcw_out_if.source  out_o,
  tcw_cfg_if.sink    cfg_i
);

  logic [7:0] attr_q, attr_d;
  logic       cmd_valid;
  cmd_t       cmd;
  bk_status_t status;

  assign cfg_i.ready = 1'b1;
  assign attr_d      = cfg_i.valid ? cfg_i.text_attribute : attr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      attr_q <= ATTR_RESET;
    end else begin
      attr_q <= attr_d;
    end
  end

  tcw_front #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_i),
    .status_i    (status),
    .cmd_valid_o (cmd_valid),
    .cmd_o       (cmd)
  );

  tcw_back #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (cmd_valid),
    .cmd_i       (cmd),
    .attr_i      (attr_q),
    .status_o    (status),
    .out_o       (out_o)
  );

  a_pop_needs_cmd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    status.pop |-> cmd_valid)
    else $error("command popped from an empty queue");

  a_pop_needs_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    status.pop |-> (!out_o.valid || out_o.ready))
    else $error("command popped while the result register is blocked");

  a_init_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !status.init_done |-> (!in_i.ready && !status.pop))
    else $error("activity during the clearing pass after reset");

  a_init_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    status.init_done |=> status.init_done)
    else $error("clearing pass flag dropped");

endmodule
